// File: hw/rtl/bmdp_pkg.sv
// ----------------------------------------------------------------------------
// Barrett modular dot product package
// Shared types, constants and register codes of the dot-product block.
// ----------------------------------------------------------------------------
package bmdp_pkg;

  localparam int unsigned HalfW  = 32;
  localparam int unsigned SumW   = 64;
  localparam int unsigned ShiftW = 6;
  localparam int unsigned CfgIdxW = 8;
  localparam int unsigned QDepth = 2;
  localparam int unsigned QPtrW  = (QDepth > 1) ? $clog2(QDepth) : 1;
  localparam int unsigned QCntW  = $clog2(QDepth + 1);

  typedef enum logic [CfgIdxW-1:0] {
    REG_MODULUS    = 8'd0,
    REG_FACTOR     = 8'd1,
    REG_PRE_SHIFT  = 8'd2,
    REG_POST_SHIFT = 8'd3
  } cfg_reg_e;

  typedef struct packed {
    logic [HalfW-1:0]  modulus;
    logic [HalfW-1:0]  barrett_factor;
    logic [ShiftW-1:0] pre_shift;
    logic [ShiftW-1:0] post_shift;
  } cfg_t;

  // Final sums of one dot product, as handed from the front to the back.
  typedef struct packed {
    logic [SumW-1:0] high_sum;
    logic [SumW-1:0] low_sum;
  } sums_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_PRE,
    S_MLO,
    S_MHI,
    S_SUM,
    S_MQ,
    S_SUB,
    S_FIX
  } back_state_e;

  // Which of the three reductions the back unit is working on.
  typedef enum logic [1:0] {
    RED_HIGH,
    RED_LOW,
    RED_COMB
  } red_step_e;

endpackage

// File: hw/rtl/bmdp_front.sv
// ----------------------------------------------------------------------------
// Dot-product front end
// Multiplies each accepted pair and accumulates the product halves.
// ----------------------------------------------------------------------------
module bmdp_front (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic [bmdp_pkg::HalfW-1:0]     left_elem_i,
  input  logic [bmdp_pkg::HalfW-1:0]     right_elem_i,
  input  logic                           last_i,
  input  logic                           q_full_i,
  output logic                           push_o,
  output bmdp_pkg::sums_t                push_data_o
);

  logic                        p_valid_q;
  logic                        p_last_q;
  logic [bmdp_pkg::SumW-1:0]   prod_q;
  logic [bmdp_pkg::SumW-1:0]   high_sum_q, high_sum_d;
  logic [bmdp_pkg::SumW-1:0]   low_sum_q, low_sum_d;
  logic                        advance;

  // The product stage only stalls when it holds a closing pair and the queue is full.
  assign advance    = !p_valid_q || !(p_last_q && q_full_i);
  assign in_ready_o = advance;

  always_comb begin
    high_sum_d = high_sum_q + {{bmdp_pkg::HalfW{1'b0}}, prod_q[bmdp_pkg::SumW-1:bmdp_pkg::HalfW]};
    low_sum_d  = low_sum_q + {{bmdp_pkg::HalfW{1'b0}}, prod_q[bmdp_pkg::HalfW-1:0]};
  end

  assign push_o               = p_valid_q && p_last_q && !q_full_i;
  assign push_data_o.high_sum = high_sum_d;
  assign push_data_o.low_sum  = low_sum_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p_valid_q  <= 1'b0;
      high_sum_q <= '0;
      low_sum_q  <= '0;
    end else if (advance) begin
      p_valid_q <= in_valid_i;
      if (p_valid_q) begin
        if (p_last_q) begin
          high_sum_q <= '0;
          low_sum_q  <= '0;
        end else begin
          high_sum_q <= high_sum_d;
          low_sum_q  <= low_sum_d;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && in_valid_i) begin
      prod_q   <= {{bmdp_pkg::HalfW{1'b0}}, left_elem_i} *
                  {{bmdp_pkg::HalfW{1'b0}}, right_elem_i};
      p_last_q <= last_i;
    end
  end

endmodule

// File: hw/rtl/bmdp_queue.sv
// ----------------------------------------------------------------------------
// Sum queue
// Short queue of finished sums between the front end and the reduction unit.
// ----------------------------------------------------------------------------
module bmdp_queue (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  bmdp_pkg::sums_t push_data_i,
  output logic            full_o,
  input  logic            pop_i,
  output logic            valid_o,
  output bmdp_pkg::sums_t head_o
);

  bmdp_pkg::sums_t                 entries_q [bmdp_pkg::QDepth];
  logic [bmdp_pkg::QPtrW-1:0]      wr_ptr_q;
  logic [bmdp_pkg::QPtrW-1:0]      rd_ptr_q;
  logic [bmdp_pkg::QCntW-1:0]      count_q;

  assign full_o  = (count_q == bmdp_pkg::QCntW'(bmdp_pkg::QDepth));
  assign valid_o = (count_q != '0);
  assign head_o  = entries_q[rd_ptr_q];

  function automatic logic [bmdp_pkg::QPtrW-1:0] next_ptr(logic [bmdp_pkg::QPtrW-1:0] p);
    logic [bmdp_pkg::QPtrW-1:0] n;
    if (p == bmdp_pkg::QPtrW'(bmdp_pkg::QDepth - 1)) begin
      n = '0;
    end else begin
      n = p + 1'b1;
    end
    return n;
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= next_ptr(wr_ptr_q);
      end
      if (pop_i) begin
        rd_ptr_q <= next_ptr(rd_ptr_q);
      end
      if (push_i && !pop_i) begin
        count_q <= count_q + 1'b1;
      end else if (pop_i && !push_i) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entries_q[wr_ptr_q] <= push_data_i;
    end
  end

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(push_i && full_o && !pop_i))
    else $error("sum queue written while full");

  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> valid_o)
    else $error("sum queue read while empty");

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= bmdp_pkg::QCntW'(bmdp_pkg::QDepth))
    else $error("sum queue count beyond depth");

endmodule

// File: hw/rtl/bmdp_back.sv
// ----------------------------------------------------------------------------
// Barrett reduction unit
// Reduces both sums and their combination with one shared 32x32 multiplier.
// ----------------------------------------------------------------------------
module bmdp_back (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  bmdp_pkg::cfg_t             cfg_i,
  input  logic                       q_valid_i,
  input  bmdp_pkg::sums_t            q_head_i,
  output logic                       pop_o,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output logic [bmdp_pkg::HalfW-1:0] out_data_o
);

  localparam int unsigned W = bmdp_pkg::HalfW;
  localparam int unsigned S = bmdp_pkg::SumW;

  bmdp_pkg::back_state_e state_q, state_d;
  bmdp_pkg::red_step_e   step_q;
  bmdp_pkg::sums_t       sums_q;
  logic [S-1:0]          x;
  logic [S-1:0]          y_q;
  logic [S-1:0]          acc_q;
  logic [W-1:0]          hi_q;
  logic [W-1:0]          quot_q;
  logic [W-1:0]          qm_q;
  logic [W-1:0]          rem_q;
  logic [W-1:0]          fixed;
  logic [W-1:0]          hr_q, lr_q;
  logic [W-1:0]          mul_a, mul_b;
  logic [S-1:0]          mul_p;
  logic [S-1:0]          sum_full;
  logic [S-1:0]          sum_shifted;
  logic                  out_free;
  logic                  out_load;
  logic                  out_valid_q;
  logic [W-1:0]          out_data_q;

  assign out_free = !out_valid_q || out_ready_i;

  always_comb begin
    case (step_q)
      bmdp_pkg::RED_HIGH: x = sums_q.high_sum;
      bmdp_pkg::RED_LOW:  x = sums_q.low_sum;
      default:            x = {hr_q, lr_q};
    endcase
  end

  always_comb begin
    case (state_q)
      bmdp_pkg::S_MLO: begin
        mul_a = y_q[W-1:0];
        mul_b = cfg_i.barrett_factor;
      end
      bmdp_pkg::S_MHI: begin
        mul_a = y_q[S-1:W];
        mul_b = cfg_i.barrett_factor;
      end
      bmdp_pkg::S_MQ: begin
        mul_a = quot_q;
        mul_b = cfg_i.modulus;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign mul_p       = {{W{1'b0}}, mul_a} * {{W{1'b0}}, mul_b};
  assign sum_full    = acc_q + {hi_q, {W{1'b0}}};
  assign sum_shifted = sum_full >> cfg_i.post_shift;
  assign fixed       = (rem_q >= cfg_i.modulus) ? (rem_q - cfg_i.modulus) : rem_q;

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      bmdp_pkg::S_IDLE: if (q_valid_i) state_d = bmdp_pkg::S_PRE;
      bmdp_pkg::S_PRE:  state_d = bmdp_pkg::S_MLO;
      bmdp_pkg::S_MLO:  state_d = bmdp_pkg::S_MHI;
      bmdp_pkg::S_MHI:  state_d = bmdp_pkg::S_SUM;
      bmdp_pkg::S_SUM:  state_d = bmdp_pkg::S_MQ;
      bmdp_pkg::S_MQ:   state_d = bmdp_pkg::S_SUB;
      bmdp_pkg::S_SUB:  state_d = bmdp_pkg::S_FIX;
      bmdp_pkg::S_FIX: begin
        if (step_q != bmdp_pkg::RED_COMB) begin
          state_d = bmdp_pkg::S_PRE;
        end else if (out_free) begin
          state_d = bmdp_pkg::S_IDLE;
        end
      end
      default: state_d = bmdp_pkg::S_IDLE;
    endcase
  end

  // Outputs of the sequencer.
  always_comb begin
    pop_o    = 1'b0;
    out_load = 1'b0;
    case (state_q)
      bmdp_pkg::S_IDLE: pop_o = q_valid_i;
      bmdp_pkg::S_FIX:  out_load = (step_q == bmdp_pkg::RED_COMB) && out_free;
      default: begin
        pop_o    = 1'b0;
        out_load = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= bmdp_pkg::S_IDLE;
      step_q      <= bmdp_pkg::RED_HIGH;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (pop_o) begin
        step_q <= bmdp_pkg::RED_HIGH;
      end else if (state_q == bmdp_pkg::S_FIX) begin
        case (step_q)
          bmdp_pkg::RED_HIGH: step_q <= bmdp_pkg::RED_LOW;
          bmdp_pkg::RED_LOW:  step_q <= bmdp_pkg::RED_COMB;
          default:            step_q <= step_q;
        endcase
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      sums_q <= q_head_i;
    end
    case (state_q)
      bmdp_pkg::S_PRE: y_q    <= x >> cfg_i.pre_shift;
      bmdp_pkg::S_MLO: acc_q  <= mul_p;
      bmdp_pkg::S_MHI: hi_q   <= mul_p[W-1:0];
      bmdp_pkg::S_SUM: quot_q <= sum_shifted[W-1:0];
      bmdp_pkg::S_MQ:  qm_q   <= mul_p[W-1:0];
      bmdp_pkg::S_SUB: rem_q  <= x[W-1:0] - qm_q;
      bmdp_pkg::S_FIX: begin
        if (step_q == bmdp_pkg::RED_HIGH) begin
          hr_q <= fixed;
        end
        if (step_q == bmdp_pkg::RED_LOW) begin
          lr_q <= fixed;
        end
      end
      default: begin
      end
    endcase
    if (out_load) begin
      out_data_q <= fixed;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  a_out_only_final: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == bmdp_pkg::S_FIX && step_q == bmdp_pkg::RED_COMB))
    else $error("result raised outside the final reduction");

endmodule

// File: hw/rtl/barrett_modular_dot_product.sv
// ----------------------------------------------------------------------------
// Barrett modular dot product
// Streams residue pairs, accumulates product halves and reduces each dot product.
// ----------------------------------------------------------------------------
// Throughput: one pair per cycle unless a closing pair waits on a full queue;
//   short runs are paced by the reduction unit's shared multiplier. Each sum
//   passes the product register, the queue, three reductions and the output register.
// Reset: asynchronous, active low; sums clear, registers take their reset values.
//
// The front end registers each pair's 64-bit product and adds its halves into
// two wrapping 64-bit sums. A pair marked last pushes the final sums into a
// two-entry queue and clears the sums, so the next vector streams in while the
// back end reduces the previous one. The back end runs three Barrett
// reductions one after the other (high sum, low sum, then the combined value
// high*2^32+low), each taking seven steps through one 32x32 multiplier: the
// 64-bit by 32-bit product modulo 2^64 is built from two partial products.
// The result waits in an output register until the downstream side takes it.
module barrett_modular_dot_product (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // Configuration channel: index selects modulus, factor, pre-shift or post-shift.
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [bmdp_pkg::CfgIdxW-1:0]    cfg_index_i,
  input  logic [bmdp_pkg::HalfW-1:0]      cfg_data_i,
  // Input stream.
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  input  logic [2*bmdp_pkg::HalfW-1:0]    s_axis_tdata,  // left_elem [31:0], right_elem [63:32]
  input  logic                            s_axis_tlast,  // last pair of the dot product
  // Result stream.
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  output logic [bmdp_pkg::HalfW-1:0]      m_axis_tdata   // dot_residue [31:0]
);

  bmdp_pkg::cfg_t  cfg_q;
  logic            q_full;
  logic            q_push;
  logic            q_pop;
  logic            q_valid;
  bmdp_pkg::sums_t q_push_data;
  bmdp_pkg::sums_t q_head;

  // Register writes are always taken; software must write only while the block is idle.
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.modulus        <= bmdp_pkg::HalfW'(1);
      cfg_q.barrett_factor <= '0;
      cfg_q.pre_shift      <= '0;
      cfg_q.post_shift     <= '0;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        bmdp_pkg::REG_MODULUS:    cfg_q.modulus        <= cfg_data_i;
        bmdp_pkg::REG_FACTOR:     cfg_q.barrett_factor <= cfg_data_i;
        bmdp_pkg::REG_PRE_SHIFT:  cfg_q.pre_shift      <= cfg_data_i[bmdp_pkg::ShiftW-1:0];
        bmdp_pkg::REG_POST_SHIFT: cfg_q.post_shift     <= cfg_data_i[bmdp_pkg::ShiftW-1:0];
        default: begin
        end
      endcase
    end
  end

  bmdp_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (s_axis_tvalid),
    .in_ready_o   (s_axis_tready),
    .left_elem_i  (s_axis_tdata[bmdp_pkg::HalfW-1:0]),
    .right_elem_i (s_axis_tdata[2*bmdp_pkg::HalfW-1:bmdp_pkg::HalfW]),
    .last_i       (s_axis_tlast),
    .q_full_i     (q_full),
    .push_o       (q_push),
    .push_data_o  (q_push_data)
  );

  bmdp_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (q_push),
    .push_data_i (q_push_data),
    .full_o      (q_full),
    .pop_i       (q_pop),
    .valid_o     (q_valid),
    .head_o      (q_head)
  );

  bmdp_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .q_valid_i   (q_valid),
    .q_head_i    (q_head),
    .pop_o       (q_pop),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_data_o  (m_axis_tdata)
  );

endmodule

// File: verif/barrett_modular_dot_product_tb.sv
// ----------------------------------------------------------------------------
// Barrett modular dot product testbench
// Streams residue vectors under many register settings and checks each
// reduced dot product against a cycle-free prediction written in this file.
// ----------------------------------------------------------------------------
module barrett_modular_dot_product_tb;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned HalfW   = bmdp_pkg::HalfW;
  localparam int unsigned SumW    = bmdp_pkg::SumW;
  localparam int unsigned ShiftW  = bmdp_pkg::ShiftW;
  localparam int unsigned CfgIdxW = bmdp_pkg::CfgIdxW;

  // Half of the 8 ns clock period.
  localparam int unsigned HalfPeriod   = 4;
  localparam int unsigned ResetCycles  = 8;
  // Settling time kept after the last predicted residue has been seen and before
  // the registers may change.
  localparam int unsigned SettleCycles = 40;
  // The slowest correct run is roughly 1200 one-pair vectors, each reduced in
  // turn, plus idling on both sides and the long hold; this limit lies far
  // beyond that, so it only trips on a hang.
  localparam int unsigned CycleLimit   = 400_000;
  localparam int unsigned HoldCycles   = 300;
  localparam int unsigned RandPhases   = 7;
  localparam int unsigned PhaseItems   = 170;
  localparam int unsigned PressurePhase = 2;
  localparam int unsigned MaxReports   = 10;

  // Indexes that select no register: writes to them must change nothing.
  localparam logic [CfgIdxW-1:0] RegIdxBeyond = 8'd4;
  localparam logic [CfgIdxW-1:0] RegIdxTop    = 8'hFF;

  localparam logic [HalfW-1:0] AllOnes   = 32'hFFFF_FFFF;
  // Largest 32-bit prime, the natural modulus for this block.
  localparam logic [HalfW-1:0] BigPrime  = 32'hFFFF_FFFB;

  typedef struct {
    logic [HalfW-1:0] left_elem;
    logic [HalfW-1:0] right_elem;
    logic             is_last;
  } pair_t;

  typedef struct {
    logic [CfgIdxW-1:0] idx;
    logic [HalfW-1:0]   data;
  } reg_write_t;

  // Clock, reset and the block's ports. Every input starts at a known value.
  logic                 clk_i         = 1'b0;
  logic                 rst_ni        = 1'b0;
  logic                 cfg_valid_i   = 1'b0;
  logic                 cfg_ready_o;
  logic [CfgIdxW-1:0]   cfg_index_i   = '0;
  logic [HalfW-1:0]     cfg_data_i    = '0;
  logic                 s_axis_tvalid = 1'b0;
  logic                 s_axis_tready;
  logic [2*HalfW-1:0]   s_axis_tdata  = '0;  // left_elem [31:0], right_elem [63:32]
  logic                 s_axis_tlast  = 1'b0; // last pair of the dot product
  logic                 m_axis_tvalid;
  logic                 m_axis_tready = 1'b0;
  logic [HalfW-1:0]     m_axis_tdata;        // dot_residue [31:0]

  // Pending pairs for the sender, register writes for the next phase, and
  // the residues predicted but not yet seen on the result stream.
  pair_t            pair_q[$];
  reg_write_t       reg_wr_q[$];
  logic [HalfW-1:0] residue_q[$];

  // Predictor state: a copy of the registers and the two wrapping sums.
  bmdp_pkg::cfg_t   model_cfg;
  logic [SumW-1:0]  high_acc;
  logic [SumW-1:0]  low_acc;

  // Idling controls, set per phase by the stimulus process.
  logic             send_idle_on = 1'b1;
  logic             recv_idle_on = 1'b1;
  logic             long_hold    = 1'b0;
  int unsigned      send_gap     = 0;
  int unsigned      recv_gap     = 0;

  int unsigned      mismatches   = 0;
  int unsigned      cycle_cnt    = 0;

  barrett_modular_dot_product u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always begin
    clk_i = 1'b1;
    #HalfPeriod;
    clk_i = 1'b0;
    #HalfPeriod;
  end

  // --------------------------------------------------------------------------
  // Prediction
  // --------------------------------------------------------------------------

  // One Barrett step exactly as the block defines it: the multiply wraps at
  // 64 bits and the remainder is cut to 32 bits before the single correction.
  // With a zero modulus the correction always fires but subtracts nothing.
  function automatic logic [HalfW-1:0] barrett_fold(logic [SumW-1:0] x);
    logic [SumW-1:0]  scaled;
    logic [SumW-1:0]  quot;
    logic [SumW-1:0]  rem_full;
    logic [HalfW-1:0] rem;
    scaled   = (x >> model_cfg.pre_shift) * {32'd0, model_cfg.barrett_factor};
    quot     = scaled >> model_cfg.post_shift;
    rem_full = x - quot * {32'd0, model_cfg.modulus};
    rem      = rem_full[HalfW-1:0];
    if (rem >= model_cfg.modulus) begin
      rem = rem - model_cfg.modulus;
    end
    return rem;
  endfunction

  // Adds one accepted pair into the sums; a last pair closes the dot product,
  // queues its predicted residue and clears the sums.
  function automatic void take_pair(logic [HalfW-1:0] a, logic [HalfW-1:0] b,
                                    logic is_last);
    logic [SumW-1:0]  prod;
    logic [HalfW-1:0] high_red;
    logic [HalfW-1:0] low_red;
    prod     = {32'd0, a} * {32'd0, b};
    high_acc = high_acc + {32'd0, prod[SumW-1:HalfW]};
    low_acc  = low_acc + {32'd0, prod[HalfW-1:0]};
    if (is_last) begin
      high_red = barrett_fold(high_acc);
      low_red  = barrett_fold(low_acc);
      residue_q.push_back(barrett_fold({high_red, low_red}));
      high_acc = '0;
      low_acc  = '0;
    end
  endfunction

  // Register write as the block sees it: shifts keep their low six bits and
  // unknown indexes are dropped.
  function automatic void note_reg_write(logic [CfgIdxW-1:0] idx,
                                         logic [HalfW-1:0] data);
    case (idx)
      bmdp_pkg::REG_MODULUS:    model_cfg.modulus        = data;
      bmdp_pkg::REG_FACTOR:     model_cfg.barrett_factor = data;
      bmdp_pkg::REG_PRE_SHIFT:  model_cfg.pre_shift      = data[ShiftW-1:0];
      bmdp_pkg::REG_POST_SHIFT: model_cfg.post_shift     = data[ShiftW-1:0];
      default: ;
    endcase
  endfunction

  // --------------------------------------------------------------------------
  // Sender: presents queued pairs, with random bursts of idle cycles between
  // transfers while idling is enabled. The prediction is updated on the edge
  // at which a pair is transferred.
  // --------------------------------------------------------------------------
  always @(posedge clk_i) begin : pair_sender
    pair_t nxt;
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready) begin
        take_pair(s_axis_tdata[HalfW-1:0], s_axis_tdata[2*HalfW-1:HalfW], s_axis_tlast);
      end
      if (!s_axis_tvalid || s_axis_tready) begin
        if (send_gap != 0) begin
          s_axis_tvalid <= 1'b0;
          send_gap      <= send_gap - 1;
        end else if (pair_q.size() != 0) begin
          nxt = pair_q.pop_front();
          s_axis_tdata  <= {nxt.right_elem, nxt.left_elem};
          s_axis_tlast  <= nxt.is_last;
          s_axis_tvalid <= 1'b1;
          if (send_idle_on && $urandom_range(0, 4) == 0) begin
            send_gap <= $urandom_range(1, 7);
          end
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Receiver: compares every transferred residue with the oldest prediction.
  // Ready drops in random bursts, and stays low throughout a long hold so the
  // block's sum queue fills and it has to refuse input.
  // --------------------------------------------------------------------------
  always @(posedge clk_i) begin : residue_checker
    logic [HalfW-1:0] want;
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (residue_q.size() == 0) begin
          mismatches <= mismatches + 1;
          if (mismatches < MaxReports) begin
            $display("unexpected dot residue %08h with nothing predicted", m_axis_tdata);
          end
        end else begin
          want = residue_q.pop_front();
          if (m_axis_tdata !== want) begin
            mismatches <= mismatches + 1;
            if (mismatches < MaxReports) begin
              $display("dot residue mismatch: expected %08h, got %08h", want, m_axis_tdata);
            end
          end
        end
      end
      if (long_hold) begin
        m_axis_tready <= 1'b0;
      end else if (recv_gap != 0) begin
        m_axis_tready <= 1'b0;
        recv_gap      <= recv_gap - 1;
      end else if (recv_idle_on && $urandom_range(0, 5) == 0) begin
        m_axis_tready <= 1'b0;
        recv_gap      <= $urandom_range(0, 6);
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  // Watchdog: a hang anywhere ends the run as a failure.
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CycleLimit) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------

  // Performs the queued register writes back to back; valid stays high from
  // one write to the next and drops after the last transfer.
  task automatic program_regs();
    reg_write_t w;
    while (reg_wr_q.size() != 0) begin
      w = reg_wr_q.pop_front();
      cfg_valid_i <= 1'b1;
      cfg_index_i <= w.idx;
      cfg_data_i  <= w.data;
      do @(posedge clk_i); while (!cfg_ready_o);
      note_reg_write(w.idx, w.data);
    end
    cfg_valid_i <= 1'b0;
  endtask

  // Queues a full setting. The shift writes carry random upper bits, which
  // the block has to discard.
  task automatic queue_cfg(logic [HalfW-1:0] p, logic [HalfW-1:0] f,
                           logic [ShiftW-1:0] s, logic [ShiftW-1:0] t);
    logic [HalfW-ShiftW-1:0] junk_s;
    logic [HalfW-ShiftW-1:0] junk_t;
    junk_s = $urandom();
    junk_t = $urandom();
    reg_wr_q.push_back('{bmdp_pkg::REG_MODULUS, p});
    reg_wr_q.push_back('{bmdp_pkg::REG_FACTOR, f});
    reg_wr_q.push_back('{bmdp_pkg::REG_PRE_SHIFT, {junk_s, s}});
    reg_wr_q.push_back('{bmdp_pkg::REG_POST_SHIFT, {junk_t, t}});
  endtask

  // Factor matching a modulus and shift pair, floor(2^(s+t)/p) cut to 32 bits.
  // The caller keeps s+t below 64.
  function automatic logic [HalfW-1:0] factor_for(logic [HalfW-1:0] p,
                                                  int unsigned s, int unsigned t);
    logic [SumW-1:0] num;
    num = 64'd1 << (s + t);
    if (p == '0) begin
      return AllOnes;
    end
    return HalfW'(num / {32'd0, p});
  endfunction

  // A setting for one random phase: a proper reduction with a large modulus,
  // a small modulus with matching but arbitrary shifts, or pure noise.
  task automatic queue_random_cfg();
    logic [HalfW-1:0] p;
    int unsigned      s;
    int unsigned      t;
    case ($urandom_range(0, 3))
      0, 1: begin
        p = $urandom_range(32'h8000_0000, AllOnes) | 32'd1;
        queue_cfg(p, factor_for(p, 31, 32), 6'd31, 6'd32);
      end
      2: begin
        p = $urandom_range(1, 5000);
        s = $urandom_range(0, 40);
        t = $urandom_range(0, 63 - s);
        queue_cfg(p, factor_for(p, s, t), ShiftW'(s), ShiftW'(t));
      end
      default: begin
        queue_cfg($urandom(), $urandom(), ShiftW'($urandom()), ShiftW'($urandom()));
      end
    endcase
  endtask

  // Element values lean towards the edges around the modulus; elements at or
  // above the modulus are legal and must be multiplied as given.
  function automatic logic [HalfW-1:0] pick_elem();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return AllOnes;
      2:       return model_cfg.modulus - 1;
      3:       return model_cfg.modulus;
      default: return $urandom();
    endcase
  endfunction

  // Queues whole vectors, each closed by a last pair, until n pairs are queued.
  task automatic add_vectors(int unsigned n, int unsigned max_len, bit allow_long);
    int unsigned remaining;
    int unsigned len;
    remaining = n;
    while (remaining > 0) begin
      if (allow_long && $urandom_range(0, 7) == 0) begin
        len = $urandom_range(9, 64);
      end else begin
        len = $urandom_range(1, max_len);
      end
      if (len > remaining) begin
        len = remaining;
      end
      for (int unsigned i = 0; i < len; i++) begin
        pair_q.push_back('{pick_elem(), pick_elem(), i == len - 1});
      end
      remaining = remaining - len;
    end
  endtask

  task automatic push_pair(logic [HalfW-1:0] a, logic [HalfW-1:0] b, logic is_last);
    pair_q.push_back('{a, b, is_last});
  endtask

  // Waits until every pair has been transferred and every predicted residue
  // has been seen, then lets the block settle before registers may change.
  // The check is made between clock edges, so that a pair taken from the
  // queue at an edge is already seen as offered.
  task automatic wait_idle();
    while (pair_q.size() != 0 || s_axis_tvalid || residue_q.size() != 0) begin
      @(negedge clk_i);
    end
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  // --------------------------------------------------------------------------
  // Test sequence
  // --------------------------------------------------------------------------
  initial begin : stimulus
    logic [HalfW-1:0] junk;
    model_cfg = '{modulus: 32'd1, barrett_factor: '0, pre_shift: '0, post_shift: '0};
    high_acc  = '0;
    low_acc   = '0;
    repeat (ResetCycles) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Registers at their reset values: a zero factor leaves the remainder as
    // the low half, less one when it is not zero.
    push_pair('0, '0, 1'b1);
    push_pair(AllOnes, AllOnes, 1'b1);
    push_pair(AllOnes, 32'd1, 1'b0);
    push_pair(32'd1, AllOnes, 1'b0);
    push_pair(32'h1234_5678, 32'h9ABC_DEF0, 1'b1);
    wait_idle();

    // A proper reduction modulo the largest 32-bit prime, with elements at
    // and above the modulus and a run of pairs that are not last.
    queue_cfg(BigPrime, factor_for(BigPrime, 31, 32), 6'd31, 6'd32);
    program_regs();
    push_pair('0, AllOnes, 1'b1);
    push_pair(BigPrime - 1, BigPrime - 1, 1'b1);
    push_pair(BigPrime, AllOnes, 1'b1);
    repeat (4) push_pair(AllOnes, AllOnes, 1'b0);
    push_pair(AllOnes, AllOnes, 1'b1);
    push_pair(32'd1, 32'd1, 1'b1);
    wait_idle();

    // Zero modulus, mixed with writes to indexes that hold no register.
    junk = $urandom();
    queue_cfg('0, $urandom(), ShiftW'($urandom()), ShiftW'($urandom()));
    reg_wr_q.push_back('{RegIdxBeyond, junk});
    reg_wr_q.push_back('{RegIdxTop, ~junk});
    program_regs();
    push_pair(AllOnes, AllOnes, 1'b0);
    push_pair(32'hDEAD_BEEF, 32'h0F0F_0F0F, 1'b1);
    push_pair('0, '0, 1'b1);
    wait_idle();

    // Extreme settings: every register at its top value, then the shifts
    // pulled apart to opposite ends.
    queue_cfg(AllOnes, AllOnes, 6'd63, 6'd63);
    program_regs();
    push_pair(AllOnes, AllOnes, 1'b1);
    push_pair(32'h8000_0000, 32'd2, 1'b1);
    wait_idle();
    queue_cfg(AllOnes, AllOnes, 6'd0, 6'd63);
    program_regs();
    push_pair(AllOnes, AllOnes, 1'b1);
    wait_idle();
    queue_cfg(AllOnes, AllOnes, 6'd63, 6'd0);
    program_regs();
    push_pair(AllOnes, AllOnes, 1'b1);
    wait_idle();

    // Random phases, each under its own setting. One phase uses very short
    // vectors while the receiver holds off, so results back up into the
    // block and it stops taking pairs. The final phase runs without idling.
    for (int unsigned ph = 0; ph < RandPhases; ph++) begin
      queue_random_cfg();
      program_regs();
      if (ph == RandPhases - 1) begin
        send_idle_on <= 1'b0;
        recv_idle_on <= 1'b0;
      end else begin
        send_idle_on <= ($urandom_range(0, 3) != 0);
        recv_idle_on <= ($urandom_range(0, 3) != 0);
      end
      if (ph == PressurePhase) begin
        add_vectors(PhaseItems, 2, 1'b0);
        long_hold <= 1'b1;
        repeat (HoldCycles) @(posedge clk_i);
        long_hold <= 1'b0;
      end else begin
        add_vectors(PhaseItems, 8, 1'b1);
      end
      wait_idle();
    end

    if (mismatches == 0 && residue_q.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
